/* hw/rtl/gmcr_pkg.sv */
// Shared constants, types and reset values for the gradient map colour ramp.
package gmcr_pkg;

   // Stop registers and how many of them the ramp uses.
   localparam int REG_COUNT       = 6;
   localparam int NUM_STOPS       = 6;
   localparam int USED_STOPS      = (NUM_STOPS > REG_COUNT) ? REG_COUNT :
                                    ((NUM_STOPS < 2) ? 2 : NUM_STOPS);
   localparam int SEGMENTS        = USED_STOPS - 1;
   localparam int CSR_INDEX_WIDTH = $clog2(REG_COUNT);
   localparam int CSR_DATA_WIDTH  = 48;

   // Data path widths.
   localparam int GRAY_WIDTH = 8;
   localparam int KEY_WIDTH  = 2 * GRAY_WIDTH;
   localparam int CHAN_WIDTH = 8;
   localparam int CHANNELS   = 4;
   localparam int NUM_WIDTH  = KEY_WIDTH + CHAN_WIDTH;

   // Pipeline depth: six front stages, then one divider stage per quotient bit.
   localparam int DIV_STEPS    = CHAN_WIDTH;
   localparam int FRONT_STAGES = 6;
   localparam int LATENCY      = FRONT_STAGES + DIV_STEPS;

   // Channel positions within a packed colour (red in the top byte).
   localparam int CH_RED   = 3;
   localparam int CH_GREEN = 2;
   localparam int CH_BLUE  = 1;
   localparam int CH_ALPHA = 0;

   typedef logic [CHANNELS-1:0][CHAN_WIDTH-1:0] color_type;

   // One stop as held in its register: colour in bits 47:16, position below.
   typedef struct packed {
      color_type             color;
      logic [KEY_WIDTH-1:0]  pos;
   } stop_type;

   typedef stop_type [REG_COUNT-1:0] stop_array_type;

   // Segment chosen for one pixel, ready for interpolation.
   typedef struct packed {
      logic                  valid;
      color_type             lo;
      color_type             hi;
      logic [KEY_WIDTH-1:0]  width;
      logic [KEY_WIDTH-1:0]  delta;
      logic [KEY_WIDTH-1:0]  rest;
   } seg_type;

   // Weighted sums per channel, waiting to be divided by the segment width.
   typedef struct packed {
      logic                                  valid;
      logic [CHANNELS-1:0][NUM_WIDTH-1:0]    num;
      logic [KEY_WIDTH-1:0]                  width;
   } sum_type;

   // Reset contents of the stop registers, last stop first.
   localparam stop_array_type STOP_RESET = {
      48'hFF7F00FFBE81,
      48'hFFFF00FF9867,
      48'h00FF00FF7F01,
      48'h0000FFFF3F81,
      48'hFF5CC5FF1967,
      48'hFF0000FF0000
   };

endpackage

/* hw/rtl/gmcr_csr.sv */
// Stop register file for the colour ramp, written through the plain write port.
module gmcr_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [gmcr_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   output gmcr_pkg::stop_array_type               stops
);

   gmcr_pkg::stop_array_type stops_ff;
   gmcr_pkg::stop_array_type stops_in;

   // A write lands in the addressed stop; indexes beyond the list are dropped.
   always_comb begin
      stops_in = stops_ff;
      for (int i = 0; i < gmcr_pkg::REG_COUNT; i++) begin
         if (csr_write_enable && (csr_index == gmcr_pkg::CSR_INDEX_WIDTH'(i))) begin
            stops_in[i] = gmcr_pkg::stop_type'(csr_write_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stops_ff <= gmcr_pkg::STOP_RESET;
      end else begin
         stops_ff <= stops_in;
      end
   end

   assign stops = stops_ff;

endmodule

/* hw/rtl/gmcr_locate.sv */
// Front stages: square the gray level, test every segment and pick the first hit.
module gmcr_locate (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [gmcr_pkg::GRAY_WIDTH-1:0]    gray,
   input  gmcr_pkg::stop_array_type           stops,
   output gmcr_pkg::seg_type                  seg
);

   localparam int SEGS = gmcr_pkg::SEGMENTS;
   localparam int KW   = gmcr_pkg::KEY_WIDTH;

   // Stage A: input register.
   logic                              a_valid_ff;
   logic [gmcr_pkg::GRAY_WIDTH-1:0]   a_gray_ff;

   // Stage B: ramp key.
   logic                              b_valid_ff;
   logic [KW-1:0]                     b_key_ff;
   logic [KW-1:0]                     b_key_in;

   // Stage C: segment tests.
   logic                              c_valid_ff;
   logic [KW-1:0]                     c_key_ff;
   logic [SEGS-1:0]                   c_hit_ff;
   logic [SEGS-1:0]                   c_hit_in;
   logic                              c_below_ff;
   logic                              c_below_in;

   // Stage D: chosen segment.
   gmcr_pkg::seg_type                 seg_ff;
   gmcr_pkg::seg_type                 seg_in;

   // Data moves on every cycle; only the valid bits are cleared by reset.
   always_ff @(posedge clock) begin
      a_gray_ff  <= gray;
      b_key_ff   <= b_key_in;
      c_key_ff   <= b_key_ff;
      c_hit_ff   <= c_hit_in;
      c_below_ff <= c_below_in;
      seg_ff.lo    <= seg_in.lo;
      seg_ff.hi    <= seg_in.hi;
      seg_ff.width <= seg_in.width;
      seg_ff.delta <= seg_in.delta;
      seg_ff.rest  <= seg_in.rest;
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         seg_ff.valid <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         seg_ff.valid <= seg_in.valid;
      end
   end

   // The key is the square of the gray level, 0 to 65025.
   assign b_key_in = KW'(a_gray_ff) * KW'(a_gray_ff);

   // Each segment is tested on its own against both of its bounds.
   always_comb begin
      for (int i = 0; i < SEGS; i++) begin
         c_hit_in[i] = (b_key_ff >= stops[i].pos) && (b_key_ff <= stops[i+1].pos);
      end
      c_below_in = b_key_ff < stops[0].pos;
   end

   // The first segment that holds the key wins. Keys outside the ramp and
   // zero-width segments become a flat segment of width one, so that the
   // divider returns the colour unchanged.
   always_comb begin
      logic [SEGS-1:0]       sel;
      logic                  taken;
      gmcr_pkg::stop_type    lo_stop;
      gmcr_pkg::stop_type    hi_stop;
      gmcr_pkg::color_type   flat;
      logic [KW-1:0]         width;
      logic [KW-1:0]         delta;

      taken   = 1'b0;
      lo_stop = '0;
      hi_stop = '0;
      for (int i = 0; i < SEGS; i++) begin
         sel[i] = c_hit_ff[i] && !taken;
         taken  = taken || c_hit_ff[i];
         if (sel[i]) begin
            lo_stop = lo_stop | stops[i];
            hi_stop = hi_stop | stops[i+1];
         end
      end
      width = hi_stop.pos - lo_stop.pos;
      delta = c_key_ff - lo_stop.pos;

      if (taken) begin
         flat = lo_stop.color;
      end else if (c_below_ff) begin
         flat = stops[0].color;
      end else begin
         flat = stops[gmcr_pkg::USED_STOPS-1].color;
      end

      seg_in.valid = c_valid_ff;
      if (taken && (width != '0)) begin
         seg_in.lo    = lo_stop.color;
         seg_in.hi    = hi_stop.color;
         seg_in.width = width;
         seg_in.delta = delta;
         seg_in.rest  = width - delta;
      end else begin
         seg_in.lo    = flat;
         seg_in.hi    = flat;
         seg_in.width = KW'(1);
         seg_in.delta = '0;
         seg_in.rest  = KW'(1);
      end
   end

   assign seg = seg_ff;

endmodule

/* hw/rtl/gmcr_lerp.sv */
// Weighting stages: form a*(w-d) + b*d for every channel of the chosen segment.
module gmcr_lerp (
   input  logic                clock,
   input  logic                reset,
   input  gmcr_pkg::seg_type   seg,
   output gmcr_pkg::sum_type   sum
);

   localparam int NW = gmcr_pkg::NUM_WIDTH;

   // Stage E: the two products per channel.
   logic                                          e_valid_ff;
   logic [gmcr_pkg::CHANNELS-1:0][NW-1:0]         e_lo_ff;
   logic [gmcr_pkg::CHANNELS-1:0][NW-1:0]         e_hi_ff;
   logic [gmcr_pkg::CHANNELS-1:0][NW-1:0]         e_lo_in;
   logic [gmcr_pkg::CHANNELS-1:0][NW-1:0]         e_hi_in;
   logic [gmcr_pkg::KEY_WIDTH-1:0]                e_width_ff;

   // Stage F: the sum handed to the divider.
   gmcr_pkg::sum_type                             sum_ff;
   gmcr_pkg::sum_type                             sum_in;

   // Data moves on every cycle; only the valid bits are cleared by reset.
   always_ff @(posedge clock) begin
      e_lo_ff      <= e_lo_in;
      e_hi_ff      <= e_hi_in;
      e_width_ff   <= seg.width;
      sum_ff.num   <= sum_in.num;
      sum_ff.width <= sum_in.width;
      if (reset) begin
         e_valid_ff   <= 1'b0;
         sum_ff.valid <= 1'b0;
      end else begin
         e_valid_ff   <= seg.valid;
         sum_ff.valid <= sum_in.valid;
      end
   end

   // One 8 by 16 bit product for each stop colour and channel.
   always_comb begin
      for (int c = 0; c < gmcr_pkg::CHANNELS; c++) begin
         e_lo_in[c] = NW'(seg.lo[c]) * NW'(seg.rest);
         e_hi_in[c] = NW'(seg.hi[c]) * NW'(seg.delta);
      end
   end

   // The sum never exceeds 255 times the width, so it fits without a carry out.
   always_comb begin
      sum_in.valid = e_valid_ff;
      sum_in.width = e_width_ff;
      for (int c = 0; c < gmcr_pkg::CHANNELS; c++) begin
         sum_in.num[c] = e_lo_ff[c] + e_hi_ff[c];
      end
   end

   assign sum = sum_ff;

endmodule

/* hw/rtl/gmcr_div.sv */
// Pipelined restoring divider: one quotient bit per stage on all four channels.
module gmcr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gmcr_pkg::sum_type     sum,
   output logic                  out_valid,
   output gmcr_pkg::color_type   quotient
);

   localparam int STEPS = gmcr_pkg::DIV_STEPS;
   localparam int LANES = gmcr_pkg::CHANNELS;
   localparam int NW    = gmcr_pkg::NUM_WIDTH;
   localparam int CW    = gmcr_pkg::CHAN_WIDTH;
   localparam int KW    = gmcr_pkg::KEY_WIDTH;

   logic [STEPS-1:0]                 valid_ff;
   logic [LANES-1:0][NW-1:0]         rem_ff   [STEPS];
   logic [LANES-1:0][NW-1:0]         rem_in   [STEPS];
   gmcr_pkg::color_type              quo_ff   [STEPS];
   gmcr_pkg::color_type              quo_in   [STEPS];
   logic [KW-1:0]                    width_ff [STEPS];

   // Operands seen by each stage: the divider input, then the stage before.
   logic [LANES-1:0][NW-1:0]         src_rem   [STEPS];
   gmcr_pkg::color_type              src_quo   [STEPS];
   logic [KW-1:0]                    src_width [STEPS];
   logic [STEPS-1:0]                 src_valid;

   always_comb begin
      src_rem[0]   = sum.num;
      src_quo[0]   = '0;
      src_width[0] = sum.width;
      src_valid[0] = sum.valid;
      for (int s = 1; s < STEPS; s++) begin
         src_rem[s]   = rem_ff[s-1];
         src_quo[s]   = quo_ff[s-1];
         src_width[s] = width_ff[s-1];
         src_valid[s] = valid_ff[s-1];
      end
   end

   // Stage s tries the width shifted up to quotient bit STEPS-1-s. The
   // remainder entering it is always below twice that shifted width.
   always_comb begin
      logic [NW-1:0] shifted;
      logic          take;

      for (int s = 0; s < STEPS; s++) begin
         shifted = NW'(src_width[s]) << (STEPS - 1 - s);
         for (int c = 0; c < LANES; c++) begin
            take = src_rem[s][c] >= shifted;
            rem_in[s][c] = take ? (src_rem[s][c] - shifted) : src_rem[s][c];
            quo_in[s][c] = {src_quo[s][c][CW-2:0], take};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STEPS; s++) begin
         rem_ff[s]   <= rem_in[s];
         quo_ff[s]   <= quo_in[s];
         width_ff[s] <= src_width[s];
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign quotient  = quo_ff[STEPS-1];

endmodule

/* hw/rtl/gradient_map_color_ramp.sv */
// Top level of the gradient map colour ramp: gray pixels in, RGBA colours out.
//
//   Channel   Handshake                   Payload
//   input     start high, busy low        req_gray
//   result    rsp_valid, one cycle        rsp_red, rsp_green, rsp_blue, rsp_alpha
//   config    csr_write_enable            csr_index, csr_write_data
//
// One pixel is taken in every cycle; busy stays low at all times.
// Each result reaches the result ports through six front stages (input,
// squaring, segment tests, segment choice, products, sum) and the eight stages
// of the restoring divider, one quotient bit each.
// Synchronous reset clears every valid bit and loads the default ramp.
// The receiver cannot stall, so the pipeline simply advances every cycle.
module gradient_map_color_ramp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [gmcr_pkg::GRAY_WIDTH-1:0]        req_gray,
   output logic                                   rsp_valid,
   output logic [gmcr_pkg::CHAN_WIDTH-1:0]        rsp_red,
   output logic [gmcr_pkg::CHAN_WIDTH-1:0]        rsp_green,
   output logic [gmcr_pkg::CHAN_WIDTH-1:0]        rsp_blue,
   output logic [gmcr_pkg::CHAN_WIDTH-1:0]        rsp_alpha,
   input  logic                                   csr_write_enable,
   input  logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [gmcr_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   gmcr_pkg::stop_array_type   stops;
   gmcr_pkg::seg_type          seg;
   gmcr_pkg::sum_type          sum;
   gmcr_pkg::color_type        quotient;
   logic                       accept;

   // The pipeline never holds off a transfer.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   gmcr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .stops            (stops)
   );

   gmcr_locate u_locate (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .gray     (req_gray),
      .stops    (stops),
      .seg      (seg)
   );

   gmcr_lerp u_lerp (
      .clock (clock),
      .reset (reset),
      .seg   (seg),
      .sum   (sum)
   );

   gmcr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .sum       (sum),
      .out_valid (rsp_valid),
      .quotient  (quotient)
   );

   // Split the packed colour onto the result ports.
   assign rsp_red   = quotient[gmcr_pkg::CH_RED];
   assign rsp_green = quotient[gmcr_pkg::CH_GREEN];
   assign rsp_blue  = quotient[gmcr_pkg::CH_BLUE];
   assign rsp_alpha = quotient[gmcr_pkg::CH_ALPHA];

endmodule

/* hw/rtl/gmcr_checker.sv */
// Port-level checks for the colour ramp, bound to the top level.
module gmcr_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic [gmcr_pkg::GRAY_WIDTH-1:0]        req_gray,
   input  logic                                   rsp_valid,
   input  logic [gmcr_pkg::CHAN_WIDTH-1:0]        rsp_red,
   input  logic [gmcr_pkg::CHAN_WIDTH-1:0]        rsp_green,
   input  logic [gmcr_pkg::CHAN_WIDTH-1:0]        rsp_blue,
   input  logic [gmcr_pkg::CHAN_WIDTH-1:0]        rsp_alpha,
   input  logic                                   csr_write_enable,
   input  logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [gmcr_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   localparam int LAT = gmcr_pkg::LATENCY;

   // Cycles since the last register write, saturating.
   logic [4:0] quiet_ff;
   logic [4:0] quiet_in;

   always_comb begin
      if (csr_write_enable) begin
         quiet_in = '0;
      end else if (quiet_ff != '1) begin
         quiet_in = quiet_ff + 5'd1;
      end else begin
         quiet_in = quiet_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_ff <= '0;
      end else begin
         quiet_ff <= quiet_in;
      end
   end

   // Every result strobe goes back to a transfer exactly one latency earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result strobe without a matching input transfer");

   // Every transfer outside reset yields a result after the fixed latency.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("input transfer produced no result");

   // Reset flushes the whole pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe straight after reset");

   // With a quiet ramp, equal neighbouring pixels give equal neighbouring colours.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && (quiet_ff >= 5'd16) &&
       ($past(req_gray, LAT) == $past(req_gray, LAT + 1)))
      |-> ((rsp_red == $past(rsp_red)) && (rsp_green == $past(rsp_green)) &&
           (rsp_blue == $past(rsp_blue)) && (rsp_alpha == $past(rsp_alpha))))
      else $error("equal pixels mapped to different colours");

endmodule

bind gradient_map_color_ramp gmcr_checker u_checker (.*);

/* sim/gradient_map_color_ramp_tb.sv */
// Self-checking testbench for the gradient map colour ramp: gray pixels in, RGBA colours out.
module gradient_map_color_ramp_tb;

   // Register indexes of the stop registers, and two indexes that decode to nothing.
   localparam logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0] IDX_STOP_0 =
      gmcr_pkg::CSR_INDEX_WIDTH'(0);
   localparam logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0] IDX_STOP_1 =
      gmcr_pkg::CSR_INDEX_WIDTH'(1);
   localparam logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0] IDX_STOP_2 =
      gmcr_pkg::CSR_INDEX_WIDTH'(2);
   localparam logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0] IDX_STOP_3 =
      gmcr_pkg::CSR_INDEX_WIDTH'(3);
   localparam logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0] IDX_STOP_4 =
      gmcr_pkg::CSR_INDEX_WIDTH'(4);
   localparam logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0] IDX_STOP_5 =
      gmcr_pkg::CSR_INDEX_WIDTH'(5);
   localparam logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0] IDX_SPARE_LOW =
      gmcr_pkg::CSR_INDEX_WIDTH'(6);
   localparam logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0] IDX_SPARE_HIGH =
      gmcr_pkg::CSR_INDEX_WIDTH'(7);

   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int IDLE_LIMIT      = 2000;
   localparam int MAX_REPORTS     = 50;

   // Default ramp after reset, stop 0 first.
   localparam logic [gmcr_pkg::CSR_DATA_WIDTH-1:0] DEFAULT_STOPS [gmcr_pkg::REG_COUNT] = '{
      48'hFF0000FF0000, 48'hFF5CC5FF1967, 48'h0000FFFF3F81,
      48'h00FF00FF7F01, 48'hFFFF00FF9867, 48'hFF7F00FFBE81
   };

   typedef enum int unsigned {SHAPE_SQUARES, SHAPE_RAW, SHAPE_SHUFFLED} ramp_shape_type;

   logic                                  clock            = 1'b0;
   logic                                  reset            = 1'b1;
   logic                                  start            = 1'b0;
   logic                                  busy;
   logic [gmcr_pkg::GRAY_WIDTH-1:0]       req_gray         = '0;
   logic                                  rsp_valid;
   logic [gmcr_pkg::CHAN_WIDTH-1:0]       rsp_red;
   logic [gmcr_pkg::CHAN_WIDTH-1:0]       rsp_green;
   logic [gmcr_pkg::CHAN_WIDTH-1:0]       rsp_blue;
   logic [gmcr_pkg::CHAN_WIDTH-1:0]       rsp_alpha;
   logic                                  csr_write_enable = 1'b0;
   logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index        = '0;
   logic [gmcr_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data   = '0;

   // Local copy of the stop registers and the colours still owed by the block.
   gmcr_pkg::stop_type    ramp_stops [gmcr_pkg::REG_COUNT];
   gmcr_pkg::color_type   pending_colors [$];
   int                    error_count = 0;
   int                    burst_left  = 0;
   int                    idle_cycles = 0;

   gradient_map_color_ramp u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_gray         (req_gray),
      .rsp_valid        (rsp_valid),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Colour for one gray level under the current stops: the first segment that holds the
   // squared key is interpolated exactly, keys outside the ramp take an end colour.
   function automatic gmcr_pkg::color_type ramp_color(
      input logic [gmcr_pkg::GRAY_WIDTH-1:0] gray);
      logic [gmcr_pkg::KEY_WIDTH-1:0] key;
      logic [gmcr_pkg::KEY_WIDTH-1:0] lo_pos;
      logic [gmcr_pkg::KEY_WIDTH-1:0] hi_pos;
      logic [gmcr_pkg::KEY_WIDTH-1:0] span;
      logic [gmcr_pkg::KEY_WIDTH-1:0] offset;
      logic [31:0]                    weighted;
      logic                           found;
      gmcr_pkg::color_type            col;
      key   = {8'd0, gray} * {8'd0, gray};
      found = 1'b0;
      col   = (key < ramp_stops[0].pos) ? ramp_stops[0].color
                                        : ramp_stops[gmcr_pkg::USED_STOPS-1].color;
      for (int s = 0; s < gmcr_pkg::USED_STOPS - 1; s++) begin
         lo_pos = ramp_stops[s].pos;
         hi_pos = ramp_stops[s+1].pos;
         if (!found && key >= lo_pos && key <= hi_pos) begin
            found  = 1'b1;
            span   = hi_pos - lo_pos;
            offset = key - lo_pos;
            if (span == '0) begin
               col = ramp_stops[s].color;
            end else begin
               for (int c = 0; c < gmcr_pkg::CHANNELS; c++) begin
                  weighted = 32'(ramp_stops[s].color[c]) * 32'(span - offset)
                           + 32'(ramp_stops[s+1].color[c]) * 32'(offset);
                  col[c]   = 8'(weighted / 32'(span));
               end
            end
         end
      end
      return col;
   endfunction

   function automatic gmcr_pkg::stop_type make_stop(input logic [31:0] rgba,
                                                    input logic [15:0] pos);
      gmcr_pkg::stop_type s;
      s.color = rgba;
      s.pos   = pos;
      return s;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $time, what);
   endtask

   // Presents one pixel, keeping the sender in bursts with random gaps between them.
   task automatic send_gray(input logic [gmcr_pkg::GRAY_WIDTH-1:0] gray);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 16);
      end
      start    <= 1'b1;
      req_gray <= gray;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_colors.push_back(ramp_color(gray));
      burst_left--;
   endtask

   // Stops the sender and waits for every outstanding colour, so the ramp may be changed.
   task automatic drain();
      start     <= 1'b0;
      burst_left = 0;
      while (pending_colors.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // One register write; the write enable is left high for the caller to lower.
   task automatic write_stop(input logic [gmcr_pkg::CSR_INDEX_WIDTH-1:0] index,
                             input logic [gmcr_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      if (index < gmcr_pkg::REG_COUNT)
         ramp_stops[index] = data;
   endtask

   task automatic load_ramp(input gmcr_pkg::stop_type s0, input gmcr_pkg::stop_type s1,
                            input gmcr_pkg::stop_type s2, input gmcr_pkg::stop_type s3,
                            input gmcr_pkg::stop_type s4, input gmcr_pkg::stop_type s5);
      write_stop(IDX_STOP_0, s0);
      write_stop(IDX_STOP_1, s1);
      write_stop(IDX_STOP_2, s2);
      write_stop(IDX_STOP_3, s3);
      write_stop(IDX_STOP_4, s4);
      write_stop(IDX_STOP_5, s5);
      csr_write_enable <= 1'b0;
   endtask

   // The ramp loaded by reset, at the extremes of the gray range and in between.
   task automatic test_default_ramp();
      send_gray(8'd0);
      send_gray(8'd1);
      send_gray(8'd81);
      send_gray(8'd128);
      send_gray(8'd200);
      send_gray(8'd254);
      send_gray(8'd255);
   endtask

   // Keys below the first stop, above the last stop and exactly on a stop.
   task automatic test_clamped_ends();
      drain();
      load_ramp(make_stop(32'h10203040, 16'h1000), make_stop(32'hFF00FF00, 16'h2400),
                make_stop(32'h00FF00FF, 16'h4000), make_stop(32'h80808080, 16'h6400),
                make_stop(32'h01020304, 16'h7000), make_stop(32'hA0B0C0D0, 16'h9000));
      send_gray(8'd0);
      send_gray(8'd255);
      send_gray(8'd64);
      send_gray(8'd160);
   endtask

   // Every stop at one position: a key on it falls in a segment of zero width.
   task automatic test_zero_width();
      drain();
      load_ramp(make_stop(32'h11223344, 16'h4000), make_stop(32'h55667788, 16'h4000),
                make_stop(32'h99AABBCC, 16'h4000), make_stop(32'hDDEEFF00, 16'h4000),
                make_stop(32'h0F1E2D3C, 16'h4000), make_stop(32'h4B5A6978, 16'h4000));
      send_gray(8'd128);
      send_gray(8'd127);
      send_gray(8'd200);
   endtask

   // All registers cleared, then all registers set.
   task automatic test_register_extremes();
      drain();
      load_ramp('0, '0, '0, '0, '0, '0);
      send_gray(8'd0);
      send_gray(8'd255);
      drain();
      load_ramp('1, '1, '1, '1, '1, '1);
      send_gray(8'd0);
      send_gray(8'd255);
   endtask

   // Positions that fall: first a ramp where no segment holds the key and both end
   // rules apply at once, then one where a later segment is the first to hold it.
   task automatic test_decreasing_positions();
      drain();
      load_ramp(make_stop(32'h12345678, 16'hF000), make_stop(32'h9ABCDEF0, 16'h9000),
                make_stop(32'h0F0F0F0F, 16'h5000), make_stop(32'hF0F0F0F0, 16'h3000),
                make_stop(32'h33333333, 16'h2000), make_stop(32'hCCCCCCCC, 16'h0100));
      send_gray(8'd128);
      drain();
      load_ramp(make_stop(32'h00000000, 16'h1000), make_stop(32'hFFFFFFFF, 16'h8000),
                make_stop(32'h20406080, 16'h2000), make_stop(32'hE0C0A080, 16'h9000),
                make_stop(32'h7F7F7F7F, 16'h0500), make_stop(32'h01FE01FE, 16'hC000));
      send_gray(8'd0);
      send_gray(8'd100);
      send_gray(8'd190);
      send_gray(8'd250);
   endtask

   // Writes to indexes past the last stop must leave the ramp untouched.
   task automatic test_spare_indexes();
      drain();
      write_stop(IDX_SPARE_LOW, {16'($urandom), 32'($urandom)});
      write_stop(IDX_SPARE_HIGH, '1);
      csr_write_enable <= 1'b0;
      send_gray(8'd90);
      send_gray(8'd170);
   endtask

   // Random ramps, mostly with rising positions, and random pixels against each.
   task automatic test_random_ramps();
      gmcr_pkg::stop_type  fresh_stops [gmcr_pkg::REG_COUNT];
      ramp_shape_type      shape;
      int unsigned         root;
      int unsigned         pos_acc;
      int unsigned         step;
      int unsigned         pick;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         shape   = ramp_shape_type'($urandom_range(0, 2));
         root    = $urandom_range(0, 40);
         pos_acc = $urandom_range(0, 8000);
         for (int i = 0; i < gmcr_pkg::REG_COUNT; i++) begin
            step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            case ($urandom_range(0, 7))
               0: fresh_stops[i].color = '0;
               1: fresh_stops[i].color = '1;
               default: fresh_stops[i].color = 32'($urandom);
            endcase
            case (shape)
               SHAPE_SQUARES: begin
                  if (i > 0)
                     root = (root + step > 255) ? 255 : root + step;
                  fresh_stops[i].pos = 16'(root * root);
               end
               SHAPE_RAW: begin
                  if (i > 0)
                     pos_acc = (pos_acc + step * 270 > 65535) ? 65535 : pos_acc + step * 270;
                  fresh_stops[i].pos = 16'(pos_acc);
               end
               default: begin
                  pick = $urandom_range(0, 255);
                  fresh_stops[i].pos = ($urandom_range(0, 1) == 0) ? 16'(pick * pick)
                                                                  : 16'($urandom);
               end
            endcase
         end
         drain();
         if ($urandom_range(0, 2) == 0)
            write_stop($urandom_range(0, 1) ? IDX_SPARE_LOW : IDX_SPARE_HIGH,
                       {16'($urandom), 32'($urandom)});
         load_ramp(fresh_stops[0], fresh_stops[1], fresh_stops[2],
                   fresh_stops[3], fresh_stops[4], fresh_stops[5]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            case ($urandom_range(0, 15))
               0: send_gray(8'd0);
               1: send_gray(8'd255);
               default: send_gray(8'($urandom_range(0, 255)));
            endcase
         end
      end
   endtask

   // Each result transfer is matched against the oldest colour still owed.
   always @(posedge clock) begin : check_results
      gmcr_pkg::color_type want;
      if (!reset && rsp_valid) begin
         if (pending_colors.size() == 0) begin
            report_mismatch("result with no pixel outstanding");
         end else begin
            want = pending_colors.pop_front();
            if (rsp_red !== want[gmcr_pkg::CH_RED])
               report_mismatch($sformatf("red %0h, expected %0h",
                                         rsp_red, want[gmcr_pkg::CH_RED]));
            if (rsp_green !== want[gmcr_pkg::CH_GREEN])
               report_mismatch($sformatf("green %0h, expected %0h",
                                         rsp_green, want[gmcr_pkg::CH_GREEN]));
            if (rsp_blue !== want[gmcr_pkg::CH_BLUE])
               report_mismatch($sformatf("blue %0h, expected %0h",
                                         rsp_blue, want[gmcr_pkg::CH_BLUE]));
            if (rsp_alpha !== want[gmcr_pkg::CH_ALPHA])
               report_mismatch($sformatf("alpha %0h, expected %0h",
                                         rsp_alpha, want[gmcr_pkg::CH_ALPHA]));
         end
      end
   end

   // Watchdog: too long without any transfer means the block has hung.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_enable) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Reset once, then run each test in turn and give the verdict.
   initial begin
      for (int i = 0; i < gmcr_pkg::REG_COUNT; i++)
         ramp_stops[i] = DEFAULT_STOPS[i];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_ramp();
      test_clamped_ends();
      test_zero_width();
      test_register_extremes();
      test_decreasing_positions();
      test_spare_indexes();
      test_random_ramps();
      drain();
      repeat (gmcr_pkg::LATENCY + 4) @(posedge clock);
      if (error_count == 0 && pending_colors.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
